/* sv/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the keyed set table
// Operation and status codes, the stored entry layout and the memory
// request bundle between the sequencer and the entry store.
// ----------------------------------------------------------------------------
package kst_pkg;

    // Widths fixed by the request and response fields
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 32;
    localparam int COUNT_OUT_W = 5;
    // Address bus width wide enough for the largest supported table
    localparam int ADDR_MAX_W  = 10;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_GET    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_DONE      = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_PDATA,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // One write port and one read port per cycle
    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        entry_t                wdata;
        logic                  re;
        logic [ADDR_MAX_W-1:0] raddr;
    } mem_req_t;

endpackage

/* sv/kst_in_if.sv */
// ----------------------------------------------------------------------------
// kst_in_if: request channel of the keyed set table
// Valid/ready handshake carrying the operation, id and handle.
// ----------------------------------------------------------------------------
interface kst_in_if import kst_pkg::*; ();

    logic                       valid;
    logic                       ready;
    mode_t                      mode;
    logic signed [KEY_W-1:0]    key_id;
    logic        [HANDLE_W-1:0] entry_handle;

    modport source (output valid, mode, key_id, entry_handle, input ready);
    modport sink   (input valid, mode, key_id, entry_handle, output ready);

endinterface

/* sv/kst_out_if.sv */
// ----------------------------------------------------------------------------
// kst_out_if: response channel of the keyed set table
// Valid/ready handshake carrying the returned entry, status and count.
// ----------------------------------------------------------------------------
interface kst_out_if import kst_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic                          found;
    logic        [HANDLE_W-1:0]    handle_out;
    logic signed [KEY_W-1:0]       id_out;
    status_t                       status;
    logic        [COUNT_OUT_W-1:0] count_out;

    modport source (output valid, found, handle_out, id_out, status, count_out,
                    input ready);
    modport sink   (input valid, found, handle_out, id_out, status, count_out,
                    output ready);

endinterface

/* sv/kst_store.sv */
// ----------------------------------------------------------------------------
// kst_store: entry memory
// CAPACITY entries of id and handle, one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
module kst_store import kst_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   rd_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    entry_t mem [CAPACITY];

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_data <= mem[mem_req.raddr[AW-1:0]];
        end
    end

endmodule

/* sv/kst_ctrl.sv */
// ----------------------------------------------------------------------------
// kst_ctrl: sequencer of the keyed set table
// Walks the entry memory one entry a cycle through a single id comparator,
// closes the gap after a remove, and holds the response register.
// ----------------------------------------------------------------------------
module kst_ctrl import kst_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    kst_in_if.sink   req,
    kst_out_if.source rsp,
    output mem_req_t mem_req,
    input  entry_t   rd_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Control state
    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;

    // Request and result payload
    mode_t              mode_reg, mode_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic               res_found_reg, res_found_next;
    entry_t             res_entry_reg, res_entry_next;
    status_t            res_status_reg, res_status_next;

    logic                   out_found_reg, out_found_next;
    entry_t                 out_entry_reg, out_entry_next;
    status_t                out_status_reg, out_status_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic more;
    logic hit;
    logic scan_end;
    logic out_free;

    // Shared compare unit and walk conditions
    assign more     = (rd_ptr_reg < count_reg);
    assign hit      = pend_reg && (rd_data.key == key_reg);
    assign scan_end = !pend_reg && !more;
    assign out_free = !out_valid_reg || rsp.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.mode == MODE_POP) ? S_POP : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (mode_reg == MODE_REMOVE) ? S_SHIFT : S_RESP;
                end
                else if (scan_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_POP:   state_next = (count_reg == '0) ? S_RESP : S_PDATA;
            S_PDATA: state_next = S_RESP;
            S_SHIFT:
            begin
                if (!pend_reg && !more)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        wr_ptr_next     = wr_ptr_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        hnd_next        = hnd_reg;
        res_found_next  = res_found_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_entry_next  = out_entry_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        // Response taken downstream
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = req.mode;
                    key_next        = req.key_id;
                    hnd_next        = req.entry_handle;
                    rd_ptr_next     = '0;
                    pend_next       = 1'b0;
                    res_found_next  = 1'b0;
                    res_entry_next  = '0;
                    res_status_next = STAT_DONE;
                end
            end
            S_SCAN, S_SHIFT:
            begin
                // Issue the next read of the walk
                if (more)
                begin
                    rd_ptr_next   = rd_ptr_reg + CW'(1);
                    pend_idx_next = rd_ptr_reg[AW-1:0];
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (state_reg == S_SCAN)
                begin
                    if (hit)
                    begin
                        if (mode_reg == MODE_ADD)
                        begin
                            res_status_next = STAT_DUPLICATE;
                        end
                        else
                        begin
                            res_found_next = 1'b1;
                            res_entry_next = rd_data;
                        end
                        // Gap closing starts one past the matched entry
                        rd_ptr_next = CW'(pend_idx_reg) + CW'(1);
                        wr_ptr_next = pend_idx_reg;
                        pend_next   = 1'b0;
                    end
                    else if (scan_end)
                    begin
                        if (mode_reg == MODE_ADD)
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                    end
                end
                else
                begin
                    // Move the fetched entry down one slot
                    if (pend_reg)
                    begin
                        wr_ptr_next = wr_ptr_reg + AW'(1);
                    end
                    if (!pend_reg && !more)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_POP:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = STAT_EMPTY;
                end
            end
            S_PDATA:
            begin
                res_found_next = 1'b1;
                res_entry_next = rd_data;
                count_next     = count_reg - CW'(1);
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_entry_next  = res_entry_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Outputs: handshake and memory port
    always_comb
    begin
        req.ready     = (state_reg == S_IDLE);
        mem_req       = '0;
        mem_req.wdata = res_entry_reg;
        case (state_reg)
            S_SCAN:
            begin
                mem_req.re    = more;
                mem_req.raddr = ADDR_MAX_W'(rd_ptr_reg);
                // Append on a miss with room left
                mem_req.we          = scan_end && (mode_reg == MODE_ADD)
                                      && (count_reg != CW'(CAPACITY));
                mem_req.waddr       = ADDR_MAX_W'(count_reg);
                mem_req.wdata.key    = key_reg;
                mem_req.wdata.handle = hnd_reg;
            end
            S_SHIFT:
            begin
                mem_req.re    = more;
                mem_req.raddr = ADDR_MAX_W'(rd_ptr_reg);
                mem_req.we    = pend_reg;
                mem_req.waddr = ADDR_MAX_W'(wr_ptr_reg);
                mem_req.wdata = rd_data;
            end
            S_POP:
            begin
                mem_req.re    = (count_reg != '0);
                mem_req.raddr = ADDR_MAX_W'(count_reg - CW'(1));
            end
            default:
            begin
                mem_req.re = 1'b0;
            end
        endcase
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.handle_out = out_entry_reg.handle;
    assign rsp.id_out     = out_entry_reg.key;
    assign rsp.status     = out_status_reg;
    assign rsp.count_out  = out_count_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        hnd_reg        <= hnd_next;
        pend_idx_reg   <= pend_idx_next;
        wr_ptr_reg     <= wr_ptr_next;
        res_found_reg  <= res_found_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_entry_reg  <= out_entry_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule

/* sv/keyed_set_table_top.sv */
// ----------------------------------------------------------------------------
// keyed_set_table_top: ordered id/handle table with add, pop, remove, get
// Entries live in a single-port-pair memory; a sequencer searches it with
// one comparator and shifts entries down after a remove.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   mode, key_id, entry_handle
//  rsp      out  valid/ready   found, handle_out, id_out, status, count_out
//
//  Search: the walk reads one entry a cycle and stops at a hit or at the
//  last entry; a remove then shifts the later entries down, and pop reads
//  the last entry.
//  Reset: rst_n clears the entry count; the memory needs no clearing.
//  Stalls: a request is taken while the prior response waits in the output
//  register; its own response waits until that register frees.
// ----------------------------------------------------------------------------
module keyed_set_table_top import kst_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    kst_in_if.sink    req,
    kst_out_if.source rsp
);

    mem_req_t mem_req;
    entry_t   rd_data;

    kst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    kst_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

/* sv/kst_checker.sv */
// ----------------------------------------------------------------------------
// kst_checker: port-level checks of the keyed set table
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module kst_checker import kst_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic                   found,
    input logic [HANDLE_W-1:0]    handle_out,
    input logic [KEY_W-1:0]       id_out,
    input logic [2:0]             status,
    input logic [COUNT_OUT_W-1:0] count_out
);

    // Held response does not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found)
        && $stable(handle_out) && $stable(id_out) && $stable(status)
        && $stable(count_out))
        else $error("response changed while stalled");

    // One request in flight: busy right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A failed operation returns no entry
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STAT_DONE)
        |-> !found && (handle_out == '0) && (id_out == '0))
        else $error("failed operation returned an entry");

    // Full means the table holds CAPACITY entries
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_FULL) |-> count_out == COUNT_OUT_W'(CAPACITY))
        else $error("full status with wrong count");

    // Empty means nothing is held
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_EMPTY) |-> count_out == '0)
        else $error("empty status with nonzero count");

endmodule

bind keyed_set_table_top kst_checker #(
    .CAPACITY (CAPACITY)
) u_kst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .found      (rsp.found),
    .handle_out (rsp.handle_out),
    .id_out     (rsp.id_out),
    .status     (rsp.status),
    .count_out  (rsp.count_out)
);
